>>> hdl/qlex_pkg.sv
// Shared types and constants for the query lexer.
// Holds the item structs, the result codes and the keyword table.
// Depends on nothing.
package qlex_pkg;

  typedef enum logic [2:0] {
    KindWord    = 3'd0,
    KindInt     = 3'd1,
    KindSpecial = 3'd2,
    KindEof     = 3'd3,
    KindError   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ErrNone      = 2'd0,
    ErrIntAlpha  = 2'd1,
    ErrLeadZero  = 2'd2
  } err_e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    kind_e      token_kind;
    logic       token_first;
    logic       token_last;
    err_e       error_code;
    logic       run_last;
  } out_t;

  // One record holds one or two results; two marks the second as used.
  typedef struct packed {
    logic two;
    out_t r0;
    out_t r1;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  localparam int unsigned KwCount = 5;
  localparam int unsigned KwStmt  = 4;

  localparam logic [7:0] KwText [KwCount][8] = '{
    '{"F", "o", "l", "l", "o", "w", "s", 8'h00},
    '{"P", "a", "r", "e", "n", "t", 8'h00, 8'h00},
    '{"C", "a", "l", "l", "s", 8'h00, 8'h00, 8'h00},
    '{"N", "e", "x", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "t", "m", "t", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] KwLen [KwCount] = '{4'd7, 4'd6, 4'd5, 4'd4, 4'd4};

  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharBar   = 8'h7C;
  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharBang  = 8'h21;
  localparam logic [7:0] CharGt    = 8'h3E;
  localparam logic [7:0] CharLt    = 8'h3C;
  localparam logic [7:0] CharSpace = 8'h20;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CharZero && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CharSpace || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_joinable(input logic [7:0] c);
    return c == CharAmp || c == CharBar || c == CharBang || c == CharEq ||
           c == CharGt || c == CharLt;
  endfunction

endpackage

>>> hdl/query_lexer_char_stream.sv
// Top level of the query lexer: front end, record queue and back end.
// Depends on qlex_pkg, qlex_front, qlex_fifo and qlex_back.
//
//   Channel   Handshake          Payload
//   input     push / full        in_item_i  (in_char, end_of_input)
//   result    empty / pop        out_item_o (out_char, token_kind, token_first,
//                                            token_last, error_code, run_last)
//
// One character is accepted per cycle while the queue has room.
// Each item gives none, one or two results; the back end delivers one per cycle while
// the output is not held, so the two results of an item leave the output in turn.
// A result passes from the head of the queue into the registered output.
// Reset returns the lexer to idle and empties the queue and output register.
// Either side may stall; the four-entry queue absorbs the difference.
module query_lexer_char_stream (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  qlex_pkg::in_t  in_item_i,
  output logic           empty,
  input  logic           pop,
  output qlex_pkg::out_t out_item_o
);

  qlex_pkg::rec_t       rec, head;
  qlex_pkg::fifo_stat_t stat;
  logic                 rec_push, rec_pop;

  assign full = stat.full;

  qlex_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (push && !stat.full),
    .in_item_i  (in_item_i),
    .rec_push_o (rec_push),
    .rec_o      (rec)
  );

  qlex_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rec_push),
    .rec_i  (rec),
    .pop_i  (rec_pop),
    .head_o (head),
    .stat_o (stat)
  );

  qlex_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .stat_i     (stat),
    .rec_pop_o  (rec_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

endmodule

>>> hdl/qlex_front.sv
// Front end of the query lexer: takes characters and classifies them.
// Holds the lexer state and builds one queue record for each item that gives results.
// Depends on qlex_pkg.
module qlex_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  qlex_pkg::in_t    in_item_i,
  output logic             rec_push_o,
  output qlex_pkg::rec_t   rec_o
);

  typedef enum logic [2:0] {
    ModeIdle  = 3'd0,
    ModeWord  = 3'd1,
    ModeNum   = 3'd2,
    ModeSpec  = 3'd3,
    ModeDrain = 3'd4
  } mode_e;

  typedef struct packed {
    logic [7:0] chr;
    logic       valid;
    logic       first;
    logic       forced;
    mode_e      mode;
    logic [4:0] cand;
    logic [3:0] pos;
    logic       lz;
  } st_t;

  st_t st_q, st_d;

  function automatic st_t clear_st();
    st_t s;
    s       = '0;
    s.mode  = ModeIdle;
    s.cand  = '1;
    return s;
  endfunction

  function automatic st_t track(input st_t s_in, input logic [7:0] c);
    st_t s;
    s = s_in;
    for (int k = 0; k < qlex_pkg::KwCount; k++) begin
      if (!(s_in.pos < qlex_pkg::KwLen[k] && qlex_pkg::KwText[k][s_in.pos[2:0]] == c)) begin
        s.cand[k] = 1'b0;
      end
    end
    if (s_in.pos != 4'hF) begin
      s.pos = s_in.pos + 4'd1;
    end
    return s;
  endfunction

  function automatic st_t start_tok(input logic [7:0] c);
    st_t s;
    s = clear_st();
    if (!qlex_pkg::is_space(c)) begin
      s.chr   = c;
      s.valid = 1'b1;
      s.first = 1'b1;
      if (qlex_pkg::is_alpha(c)) begin
        s.mode = ModeWord;
        s      = track(s, c);
      end else if (qlex_pkg::is_digit(c)) begin
        s.mode = ModeNum;
        s.lz   = (c == qlex_pkg::CharZero);
        s.pos  = 4'd1;
      end else begin
        s.mode   = ModeSpec;
        s.forced = !qlex_pkg::is_joinable(c);
      end
    end
    return s;
  endfunction

  function automatic st_t hold_next(input st_t s_in, input logic [7:0] c, input logic f);
    st_t s;
    s        = s_in;
    s.chr    = c;
    s.first  = 1'b0;
    s.forced = f;
    return s;
  endfunction

  function automatic qlex_pkg::out_t mk(input logic [7:0] ch, input qlex_pkg::kind_e kind,
                                        input logic fst, input logic lst,
                                        input qlex_pkg::err_e err);
    qlex_pkg::out_t r;
    r.out_char    = ch;
    r.token_kind  = kind;
    r.token_first = fst;
    r.token_last  = lst;
    r.error_code  = err;
    r.run_last    = 1'b0;
    return r;
  endfunction

  qlex_pkg::kind_e held_kind;
  logic            lz_bad;
  logic            kw_star;
  logic            kw_hash;
  logic            join_ok;
  logic [1:0]      n;
  qlex_pkg::out_t  r0, r1;
  logic [7:0]      c;
  st_t             drain_st;

  always_comb begin
    case (st_q.mode)
      ModeWord: held_kind = qlex_pkg::KindWord;
      ModeNum:  held_kind = qlex_pkg::KindInt;
      default:  held_kind = qlex_pkg::KindSpecial;
    endcase
  end

  always_comb begin
    c       = in_item_i.in_char;
    lz_bad  = st_q.lz && st_q.pos > 4'd1;
    kw_star = 1'b0;
    for (int k = 0; k < qlex_pkg::KwStmt; k++) begin
      kw_star = kw_star || (st_q.cand[k] && st_q.pos == qlex_pkg::KwLen[k]);
    end
    kw_hash = st_q.cand[qlex_pkg::KwStmt] &&
              st_q.pos == qlex_pkg::KwLen[qlex_pkg::KwStmt];
    join_ok = (st_q.chr == qlex_pkg::CharBar && c == qlex_pkg::CharBar) ||
              (st_q.chr == qlex_pkg::CharAmp && c == qlex_pkg::CharAmp) ||
              ((st_q.chr == qlex_pkg::CharBang || st_q.chr == qlex_pkg::CharEq ||
                st_q.chr == qlex_pkg::CharGt || st_q.chr == qlex_pkg::CharLt) &&
               c == qlex_pkg::CharEq);
    drain_st      = clear_st();
    drain_st.mode = ModeDrain;
    st_d = st_q;
    n    = 2'd0;
    r0   = mk(8'h00, qlex_pkg::KindEof, 1'b1, 1'b1, qlex_pkg::ErrNone);
    r1   = r0;
    if (in_item_i.end_of_input) begin
      if (st_q.mode != ModeDrain && st_q.valid) begin
        if (st_q.mode == ModeNum && lz_bad) begin
          r0 = mk(8'h00, qlex_pkg::KindError, 1'b1, 1'b1, qlex_pkg::ErrLeadZero);
        end else begin
          r0 = mk(st_q.chr, held_kind, st_q.first, 1'b1, qlex_pkg::ErrNone);
        end
        n = 2'd2;
      end else begin
        n = 2'd1;
      end
      st_d = clear_st();
    end else if (st_q.mode == ModeDrain) begin
      n = 2'd0;
    end else if (!st_q.valid || st_q.mode == ModeIdle) begin
      st_d = start_tok(c);
    end else if (st_q.forced) begin
      n    = 2'd1;
      r0   = mk(st_q.chr, held_kind, st_q.first, 1'b1, qlex_pkg::ErrNone);
      st_d = start_tok(c);
    end else if (st_q.mode == ModeWord) begin
      n = 2'd1;
      if (qlex_pkg::is_alpha(c) || qlex_pkg::is_digit(c)) begin
        r0   = mk(st_q.chr, held_kind, st_q.first, 1'b0, qlex_pkg::ErrNone);
        st_d = hold_next(track(st_q, c), c, 1'b0);
      end else if ((c == qlex_pkg::CharStar && kw_star) ||
                   (c == qlex_pkg::CharHash && kw_hash)) begin
        r0   = mk(st_q.chr, held_kind, st_q.first, 1'b0, qlex_pkg::ErrNone);
        st_d = hold_next(st_q, c, 1'b1);
      end else begin
        r0   = mk(st_q.chr, held_kind, st_q.first, 1'b1, qlex_pkg::ErrNone);
        st_d = start_tok(c);
      end
    end else if (st_q.mode == ModeNum) begin
      n = 2'd1;
      if (qlex_pkg::is_digit(c)) begin
        r0   = mk(st_q.chr, held_kind, st_q.first, 1'b0, qlex_pkg::ErrNone);
        st_d = hold_next(st_q, c, 1'b0);
        if (st_q.pos != 4'hF) begin
          st_d.pos = st_q.pos + 4'd1;
        end
      end else if (qlex_pkg::is_alpha(c)) begin
        r0   = mk(8'h00, qlex_pkg::KindError, 1'b1, 1'b1, qlex_pkg::ErrIntAlpha);
        st_d = drain_st;
      end else if (lz_bad) begin
        r0   = mk(8'h00, qlex_pkg::KindError, 1'b1, 1'b1, qlex_pkg::ErrLeadZero);
        st_d = drain_st;
      end else begin
        r0   = mk(st_q.chr, held_kind, st_q.first, 1'b1, qlex_pkg::ErrNone);
        st_d = start_tok(c);
      end
    end else begin
      n = 2'd1;
      if (join_ok) begin
        r0   = mk(st_q.chr, held_kind, st_q.first, 1'b0, qlex_pkg::ErrNone);
        st_d = hold_next(st_q, c, 1'b1);
      end else begin
        r0   = mk(st_q.chr, held_kind, st_q.first, 1'b1, qlex_pkg::ErrNone);
        st_d = start_tok(c);
      end
    end
    if (n == 2'd2) begin
      r1.run_last = 1'b1;
    end else begin
      r0.run_last = 1'b1;
    end
  end

  assign rec_push_o = accept_i && (n != 2'd0);
  assign rec_o      = '{two: (n == 2'd2), r0: r0, r1: r1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= clear_st();
    end else if (accept_i) begin
      st_q <= st_d;
    end
  end

endmodule

>>> hdl/qlex_fifo.sv
// Short record queue between the front and back ends of the query lexer.
// Holds up to FifoDepth records of one or two results each.
// Depends on qlex_pkg.
module qlex_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  qlex_pkg::rec_t       rec_i,
  input  logic                 pop_i,
  output qlex_pkg::rec_t       head_o,
  output qlex_pkg::fifo_stat_t stat_o
);

  qlex_pkg::rec_t                 mem_q [qlex_pkg::FifoDepth];
  logic [qlex_pkg::FifoAw-1:0]    wptr_q, rptr_q;
  logic [qlex_pkg::FifoAw:0]      cnt_q;
  logic                           do_push, do_pop;

  assign stat_o.full  = (cnt_q == (qlex_pkg::FifoAw + 1)'(qlex_pkg::FifoDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (qlex_pkg::FifoAw + 1)'(qlex_pkg::FifoDepth))
    else $error("Queue count exceeds its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && stat_o.full))
    else $error("Record pushed into a full queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && stat_o.empty))
    else $error("Record popped from an empty queue.");

endmodule

>>> hdl/qlex_back.sv
// Back end of the query lexer: unpacks queue records into single results.
// Holds the output register and the selector for the second result.
// Depends on qlex_pkg.
module qlex_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qlex_pkg::rec_t       head_i,
  input  qlex_pkg::fifo_stat_t stat_i,
  output logic                 rec_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output qlex_pkg::out_t       out_item_o
);

  logic           out_valid_q, out_valid_d;
  logic           sel_q, sel_d;
  logic           load;
  qlex_pkg::out_t out_q;

  assign load  = !out_valid_q || pop_i;
  assign empty_o = !out_valid_q;
  assign out_item_o = out_q;

  always_comb begin
    rec_pop_o   = 1'b0;
    sel_d       = sel_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = !stat_i.empty;
      if (!stat_i.empty) begin
        if (!sel_q && head_i.two) begin
          sel_d = 1'b1;
        end else begin
          rec_pop_o = 1'b1;
          sel_d     = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !stat_i.empty) begin
      out_q <= sel_q ? head_i.r1 : head_i.r0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (!stat_i.empty && head_i.two))
    else $error("Second result selected without a two-result record.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_pop_o |=> out_valid_q)
    else $error("Record retired without a result loaded.");

endmodule
